@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the distance field splat block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/sdfs_pkg.sv @@
// Shared constants for the sphere distance field splat block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sdfs_pkg;

   localparam int GRID_X_DEF = 64;
   localparam int GRID_Y_DEF = 64;
   localparam int GRID_Z_DEF = 64;

   localparam logic signed [31:0] FAR_VALUE = 32'sh7FFF_FFFF;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [1:0] ACT_SPLAT = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_SKIPPED = 2'd1;
   localparam logic [1:0] STAT_READ    = 2'd2;

   localparam logic [2:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z   = 3'd2;
   localparam logic [2:0] CSR_CELL_SIZE  = 3'd3;
   localparam logic [2:0] CSR_INV_CELL   = 3'd4;
   localparam logic [2:0] CSR_RAD_SCALE  = 3'd5;
   localparam logic [2:0] CSR_MAX_RADIUS = 3'd6;

endpackage

@@ hw/rtl/sphere_distance_field_splat.sv @@
// Sphere splat distance field: sequencer around a shared multiplier,
// an iterative square root and the grid memory. A clear writes every cell in
// turn; a splat visits each corner of its clipped box in turn.
// One word at a time; start is taken only while busy is low. Results pulse
// one cycle on rsp_valid and cannot be stalled. Synchronous reset restores the
// register defaults and runs a clearing pass over all GRID_X*GRID_Y*GRID_Z cells.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sphere_distance_field_splat
   import sdfs_pkg::*;
#(
   parameter int GRID_X = GRID_X_DEF,
   parameter int GRID_Y = GRID_Y_DEF,
   parameter int GRID_Z = GRID_Z_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic [30:0]        req_radius,
   input  logic [17:0]        req_voxel_index,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_distance,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int TOTAL = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(TOTAL);
   localparam int MAXD  = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                            : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
   localparam int IW    = $clog2(MAXD) + 1;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_CLR  = 5'd1;
   localparam logic [4:0] S_RD   = 5'd2;
   localparam logic [4:0] S_RDW  = 5'd3;
   localparam logic [4:0] S_RSP  = 5'd4;
   localparam logic [4:0] S_MR   = 5'd5;
   localparam logic [4:0] S_MG   = 5'd6;
   localparam logic [4:0] S_G    = 5'd7;
   localparam logic [4:0] S_TOP  = 5'd8;
   localparam logic [4:0] S_INS  = 5'd9;
   localparam logic [4:0] S_LO   = 5'd10;
   localparam logic [4:0] S_HI   = 5'd11;
   localparam logic [4:0] S_CHK  = 5'd12;
   localparam logic [4:0] S_VADR = 5'd13;
   localparam logic [4:0] S_VP   = 5'd14;
   localparam logic [4:0] S_VD   = 5'd15;
   localparam logic [4:0] S_VS   = 5'd16;
   localparam logic [4:0] S_SQ   = 5'd17;
   localparam logic [4:0] S_SQW  = 5'd18;

   // configuration
   logic signed [31:0] org_ff [0:2];
   logic signed [31:0] org_in [0:2];
   logic [30:0] cell_ff, cell_in, inv_ff, inv_in, maxr_ff, maxr_in;
   logic [23:0] scale_ff, scale_in;

   // sequencer and item
   logic [4:0]  state_ff, state_in;
   logic [1:0]  ax_ff, ax_in;
   logic signed [31:0] c_ff [0:2];
   logic signed [31:0] c_in [0:2];
   logic [30:0] rad_ff, rad_in;
   logic [17:0] vidx_ff, vidx_in;
   logic [30:0] r_ff, r_in;
   logic [39:0] g_ff, g_in;
   logic        skip_ff, skip_in;
   logic [IW-1:0] lo_ff [0:2];
   logic [IW-1:0] lo_in [0:2];
   logic [IW-1:0] hi_ff [0:2];
   logic [IW-1:0] hi_in [0:2];
   logic [IW-1:0] idx_ff [0:2];
   logic [IW-1:0] idx_in [0:2];
   logic [AW-1:0] addr_ff, addr_in, clr_ff, clr_in;
   logic        clr_rsp_ff, clr_rsp_in;
   logic [63:0] acc_ff, acc_in;
   logic        far_ff, far_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_dist_ff, rsp_dist_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // datapath
   logic [IW-1:0] nm1 [0:2];
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic signed [43:0] org_e, c_e, g_e, top_s, lo_lim, hi_lim, dv, dmag44;
   logic signed [34:0] dlo, dhi;
   logic [32:0] dlo_pos, dhi_pos, q_lo, q_lom1;
   logic [33:0] q_hi;
   logic [31:0] dmag;
   logic        dbig, inside_ok, empty, last_x, last_y, last_z;
   logic [64:0] acc_sum;
   logic [38:0] rs;
   logic signed [33:0] v_s;
   logic signed [31:0] d_new;
   logic        sq_start, sq_done;
   logic [31:0] sq_root;
   logic        wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic signed [31:0] wr_data, rd_data;
   logic        accept, in_range;

   assign nm1[0] = IW'(GRID_X - 1);
   assign nm1[1] = IW'(GRID_Y - 1);
   assign nm1[2] = IW'(GRID_Z - 1);

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign org_e  = 44'(org_ff[ax_ff]);
   assign c_e    = 44'(c_ff[ax_ff]);
   assign g_e    = $signed({4'b0, g_ff});
   // corner position origin + i*cell; also the grid top when i = n-1
   assign top_s  = org_e + $signed({3'b0, mul_p[40:0]});
   assign lo_lim = org_e - g_e;
   assign hi_lim = top_s + g_e;
   assign inside_ok = (c_e >= lo_lim) && (c_e <= hi_lim);

   assign dlo = 35'(c_ff[ax_ff]) - $signed({4'b0, r_ff}) - 35'(org_ff[ax_ff]);
   assign dhi = 35'(c_ff[ax_ff]) + $signed({4'b0, r_ff}) - 35'(org_ff[ax_ff]);
   assign dlo_pos = dlo[34] ? 33'd0 : dlo[32:0];
   assign dhi_pos = dhi[34] ? 33'd0 : dhi[32:0];
   assign q_lo   = mul_p[64:32];
   assign q_lom1 = q_lo - 33'd1;
   assign q_hi   = {1'b0, mul_p[64:32]} + 34'd1;

   assign dv     = c_e - top_s;
   assign dmag44 = dv[43] ? -dv : dv;
   assign dbig   = |dmag44[43:32];
   assign dmag   = dmag44[31:0];
   assign acc_sum = {1'b0, acc_ff} + {1'b0, mul_p[63:0]};

   assign rs  = mul_p[54:16];
   assign v_s = $signed({2'b0, sq_root}) - $signed({3'b0, r_ff});
   always_comb begin
      if (far_ff || (!v_s[33] && (v_s[32] || v_s[31]))) begin
         d_new = FAR_VALUE;
      end else begin
         d_new = v_s[31:0];
      end
   end

   assign empty  = (lo_ff[0] > hi_ff[0]) || (lo_ff[1] > hi_ff[1]) || (lo_ff[2] > hi_ff[2]);
   assign last_x = (idx_ff[0] == hi_ff[0]);
   assign last_y = (idx_ff[1] == hi_ff[1]);
   assign last_z = (idx_ff[2] == hi_ff[2]);
   assign in_range = (32'(vidx_ff) < 32'(TOTAL));

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MR: begin
            mul_a = MUL_A_W'(rad_ff);
            mul_b = MUL_B_W'(scale_ff);
         end
         S_MG: begin
            mul_a = MUL_A_W'(maxr_ff);
            mul_b = MUL_B_W'(scale_ff);
         end
         S_TOP: begin
            mul_a = MUL_A_W'(nm1[ax_ff]);
            mul_b = MUL_B_W'(cell_ff);
         end
         S_INS: begin
            mul_a = dlo_pos;
            mul_b = MUL_B_W'(inv_ff);
         end
         S_LO: begin
            mul_a = dhi_pos;
            mul_b = MUL_B_W'(inv_ff);
         end
         S_VP: begin
            mul_a = MUL_A_W'(idx_ff[ax_ff]);
            mul_b = MUL_B_W'(cell_ff);
         end
         S_VD: begin
            mul_a = MUL_A_W'(dmag);
            mul_b = dmag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // grid port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = d_new;
      rd_en   = 1'b0;
      rd_addr = addr_ff;
      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = FAR_VALUE;
         end
         S_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(vidx_ff);
         end
         S_VP: begin
            rd_en = 1'b1;
         end
         S_SQW: begin
            wr_en = sq_done && (d_new < rd_data);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign sq_start = (state_ff == S_SQ);

   always_comb begin
      org_in   = org_ff;
      cell_in  = cell_ff;
      inv_in   = inv_ff;
      scale_in = scale_ff;
      maxr_in  = maxr_ff;
      state_in = state_ff;
      ax_in    = ax_ff;
      c_in     = c_ff;
      rad_in   = rad_ff;
      vidx_in  = vidx_ff;
      r_in     = r_ff;
      g_in     = g_ff;
      skip_in  = skip_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      idx_in   = idx_ff;
      addr_in  = addr_ff;
      clr_in   = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      acc_in   = acc_ff;
      far_in   = far_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = (state_ff == S_RSP);

      if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:   org_in[0] = csr_wdata;
            CSR_ORIGIN_Y:   org_in[1] = csr_wdata;
            CSR_ORIGIN_Z:   org_in[2] = csr_wdata;
            CSR_CELL_SIZE:  cell_in   = csr_wdata[30:0];
            CSR_INV_CELL:   inv_in    = csr_wdata[30:0];
            CSR_RAD_SCALE:  scale_in  = csr_wdata[23:0];
            CSR_MAX_RADIUS: maxr_in   = csr_wdata[30:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               c_in[0] = req_center_x;
               c_in[1] = req_center_y;
               c_in[2] = req_center_z;
               rad_in  = req_radius;
               vidx_in = req_voxel_index;
               rsp_dist_in   = '0;
               rsp_status_in = STAT_DONE;
               case (req_action)
                  ACT_SPLAT: begin
                     state_in = S_MR;
                     ax_in    = 2'd0;
                     skip_in  = 1'b0;
                  end
                  ACT_READ: state_in = S_RD;
                  ACT_CLEAR: begin
                     state_in   = S_CLR;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                  end
                  default: state_in = S_RSP;
               endcase
            end
         end
         S_CLR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(TOTAL - 1)) begin
               state_in = clr_rsp_ff ? S_RSP : S_IDLE;
            end
         end
         S_RD: state_in = S_RDW;
         S_RDW: begin
            rsp_dist_in   = in_range ? rd_data : FAR_VALUE;
            rsp_status_in = STAT_READ;
            state_in      = S_RSP;
         end
         S_RSP: state_in = S_IDLE;
         S_MR: state_in = S_MG;
         S_MG: begin
            // scaled radius, saturated
            r_in     = (|rs[38:31]) ? 31'h7FFF_FFFF : rs[30:0];
            state_in = S_G;
         end
         S_G: begin
            g_in     = mul_p[54:15];
            state_in = S_TOP;
         end
         S_TOP: state_in = S_INS;
         S_INS: begin
            if (!inside_ok) begin
               skip_in = 1'b1;
            end
            state_in = S_LO;
         end
         S_LO: begin
            if (q_lo == 33'd0) begin
               lo_in[ax_ff] = '0;
            end else if (q_lom1 > 33'(nm1[ax_ff])) begin
               lo_in[ax_ff] = nm1[ax_ff] + IW'(1);  // past the grid: box is empty
            end else begin
               lo_in[ax_ff] = q_lom1[IW-1:0];
            end
            state_in = S_HI;
         end
         S_HI: begin
            hi_in[ax_ff] = (q_hi < 34'(nm1[ax_ff])) ? q_hi[IW-1:0] : nm1[ax_ff];
            if (ax_ff == 2'd2) begin
               state_in = S_CHK;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_TOP;
            end
         end
         S_CHK: begin
            idx_in = lo_ff;
            ax_in  = 2'd0;
            acc_in = '0;
            far_in = 1'b0;
            if (skip_ff) begin
               rsp_status_in = STAT_SKIPPED;
               state_in      = S_RSP;
            end else if (empty) begin
               state_in = S_RSP;
            end else begin
               state_in = S_VADR;
            end
         end
         S_VADR: begin
            addr_in = AW'((32'(idx_ff[2]) * 32'(GRID_Y) + 32'(idx_ff[1])) * 32'(GRID_X)
                          + 32'(idx_ff[0]));
            state_in = S_VP;
         end
         S_VP: state_in = S_VD;
         S_VD: begin
            if (dbig) begin
               far_in = 1'b1;
            end
            state_in = S_VS;
         end
         S_VS: begin
            acc_in = acc_sum[63:0];
            if (acc_sum[64]) begin
               far_in = 1'b1;
            end
            if (ax_ff == 2'd2) begin
               state_in = S_SQ;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_VP;
            end
         end
         S_SQ: state_in = S_SQW;
         S_SQW: begin
            if (sq_done) begin
               ax_in  = 2'd0;
               acc_in = '0;
               far_in = 1'b0;
               state_in = S_VADR;
               if (!last_x) begin
                  idx_in[0] = idx_ff[0] + IW'(1);
               end else begin
                  idx_in[0] = lo_ff[0];
                  if (!last_y) begin
                     idx_in[1] = idx_ff[1] + IW'(1);
                  end else begin
                     idx_in[1] = lo_ff[1];
                     if (!last_z) begin
                        idx_in[2] = idx_ff[2] + IW'(1);
                     end else begin
                        state_in = S_RSP;
                     end
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= '0;
         org_ff[0]    <= '0;
         org_ff[1]    <= '0;
         org_ff[2]    <= '0;
         cell_ff      <= 31'd65536;
         inv_ff       <= 31'd65536;
         scale_ff     <= 24'd65536;
         maxr_ff      <= 31'd65536;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         ax_ff        <= ax_in;
         org_ff       <= org_in;
         cell_ff      <= cell_in;
         inv_ff       <= inv_in;
         scale_ff     <= scale_in;
         maxr_ff      <= maxr_in;
      end
      c_ff          <= c_in;
      rad_ff        <= rad_in;
      vidx_ff       <= vidx_in;
      r_ff          <= r_in;
      g_ff          <= g_in;
      skip_ff       <= skip_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      addr_ff       <= addr_in;
      acc_ff        <= acc_in;
      far_ff        <= far_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_status   = rsp_status_ff;

   sdfs_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   sdfs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   sdfs_grid #(
      .DEPTH (TOTAL),
      .AW    (AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // an accepted word always keeps the sequencer busy in the cycle after it is taken
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   // results never come in adjacent cycles
   `ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   // root completes only while the sequencer waits for it
   `ASSERT_ALWAYS(a_sqrt_wait, clock, reset, !sq_done || (state_ff == S_SQW))

endmodule

@@ hw/rtl/sdfs_mul.sv @@
// Shared unsigned multiplier with a registered product.
// Depends on sdfs_pkg for operand widths.
`timescale 1ns / 1ps

module sdfs_mul
   import sdfs_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] p
);

   logic [MUL_P_W-1:0] p_ff;
   logic [MUL_P_W-1:0] p_in;

   assign p_in = MUL_P_W'(a) * MUL_P_W'(b);
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

@@ hw/rtl/sdfs_sqrt.sv @@
// Iterative integer square root of a 64-bit word, two radicand bits a cycle.
// Depends on sdfs_pkg (imported for house consistency of types).
`timescale 1ns / 1ps

module sdfs_sqrt
   import sdfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] rad_ff, rad_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [34:0] rem_n, trial;

   assign rem_n = {rem_ff[32:0], rad_ff[63:62]};
   assign trial = {1'b0, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_n >= trial) begin
            rem_in  = rem_n - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_n;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/sdfs_grid.sv @@
// Distance grid storage: one write port, one registered read port.
// Depends on sdfs_pkg; depth and address width come from the top level.
`timescale 1ns / 1ps

module sdfs_grid
   import sdfs_pkg::*;
#(
   parameter int DEPTH = GRID_X_DEF * GRID_Y_DEF * GRID_Z_DEF,
   parameter int AW    = $clog2(DEPTH)
)
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic signed [31:0]   wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic signed [31:0]   rd_data
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for the sphere distance field splat block: random and directed
// splats and reads plus directed clears, checked against an in-bench grid predictor.
// Depends on sdfs_pkg and sphere_distance_field_splat.
`timescale 1ns / 1ps

module testbench;
   import sdfs_pkg::*;

   localparam int GX = GRID_X_DEF;
   localparam int GY = GRID_Y_DEF;
   localparam int GZ = GRID_Z_DEF;
   localparam int VOXELS = GX * GY * GZ;
   localparam logic [2:0] CSR_NONE = 3'd7;

   typedef struct {
      logic [1:0]         action;
      logic signed [31:0] cx, cy, cz;
      logic [30:0]        radius;
      logic [17:0]        vidx;
   } sphere_word_type;

   typedef struct {
      logic signed [31:0] distance;
      logic [1:0]         status;
   } field_result_type;

   logic clock, reset, start, busy, rsp_valid, csr_we;
   logic [1:0] req_action, rsp_status;
   logic signed [31:0] req_center_x, req_center_y, req_center_z, rsp_distance;
   logic [30:0] req_radius;
   logic [17:0] req_voxel_index;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   sphere_distance_field_splat dut (.*);

   // predictor state
   logic signed [31:0] sdf_grid [0:VOXELS-1];
   longint org_x, org_y, org_z;
   longint unsigned cell_q, inv_q, rscale_q, maxr_q;
   int touched [$];

   sphere_word_type pending_words [$];
   sphere_word_type live_word, next_word;
   field_result_type expected_results [$];
   field_result_type got;
   int sender_idle;
   int fails;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #300ms;
      $display("[sphere_distance_field_splat] ERROR");
      $finish;
   end

   function automatic longint unsigned cell_index(longint d);
      bit [63:0] p;
      if (d < 0) return 0;
      p = 64'(d) * inv_q;
      return p >> 32;
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] corner_dist(longint dx, longint dy, longint dz,
                                                      longint r);
      bit [63:0] acc = 0, m, sq;
      longint d [3];
      longint v;
      d = '{dx, dy, dz};
      foreach (d[k]) begin
         m = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
         if (m >= 64'h1_0000_0000) return FAR_VALUE;
         sq = m * m;
         if (acc > ~64'd0 - sq) return FAR_VALUE;
         acc += sq;
      end
      v = longint'(int_sqrt(acc)) - r;
      if (v > longint'(FAR_VALUE)) return FAR_VALUE;
      return v[31:0];
   endfunction

   function automatic bit in_reach(longint c, longint o, int n);
      longint g, top;
      g = longint'((2 * maxr_q * rscale_q) >> 16);
      top = o + longint'(n - 1) * longint'(cell_q);
      return c >= o - g && c <= top + g;
   endfunction

   function automatic bit splat_taken(sphere_word_type w);
      return in_reach(longint'(w.cx), org_x, GX) && in_reach(longint'(w.cy), org_y, GY) &&
             in_reach(longint'(w.cz), org_z, GZ);
   endfunction

   function automatic void axis_span(longint c, longint r, longint o, int n,
                                     output longint unsigned lo, output longint unsigned hi);
      longint unsigned q;
      q = cell_index(c - r - o);
      lo = q > 0 ? q - 1 : 0;
      q = cell_index(c + r - o) + 1;
      hi = q < longint'(n - 1) ? q : longint'(n - 1);
   endfunction

   function automatic logic [1:0] splat_sphere(sphere_word_type w);
      longint unsigned rs, x0, x1, y0, y1, z0, z1, i;
      longint r, cx, cy, cz, dx, dy, dz;
      logic signed [31:0] dv;
      cx = longint'(w.cx);
      cy = longint'(w.cy);
      cz = longint'(w.cz);
      rs = (longint'(w.radius) * rscale_q) >> 16;
      r = rs > 64'h7FFF_FFFF ? longint'(FAR_VALUE) : longint'(rs);
      if (!splat_taken(w)) return STAT_SKIPPED;
      axis_span(cx, r, org_x, GX, x0, x1);
      axis_span(cy, r, org_y, GY, y0, y1);
      axis_span(cz, r, org_z, GZ, z0, z1);
      for (longint unsigned z = z0; z <= z1; z++) begin
         dz = cz - (org_z + longint'(z) * longint'(cell_q));
         for (longint unsigned y = y0; y <= y1; y++) begin
            dy = cy - (org_y + longint'(y) * longint'(cell_q));
            for (longint unsigned x = x0; x <= x1; x++) begin
               dx = cx - (org_x + longint'(x) * longint'(cell_q));
               i = (z * GY + y) * GX + x;
               dv = corner_dist(dx, dy, dz, r);
               if (i < VOXELS && dv < sdf_grid[i]) begin
                  sdf_grid[i] = dv;
                  touched.push_back(int'(i));
                  if (touched.size() > 64) void'(touched.pop_front());
               end
            end
         end
      end
      return STAT_DONE;
   endfunction

   function automatic field_result_type predict_word(sphere_word_type w);
      field_result_type res = '{distance: 0, status: STAT_DONE};
      case (w.action)
         ACT_SPLAT: res.status = splat_sphere(w);
         ACT_READ: begin
            res.distance = w.vidx < VOXELS ? sdf_grid[w.vidx] : FAR_VALUE;
            res.status = STAT_READ;
         end
         ACT_CLEAR: foreach (sdf_grid[k]) sdf_grid[k] = FAR_VALUE;
         default: ;
      endcase
      return res;
   endfunction

   // driver: a word is taken on an edge with start high and busy low
   always @(posedge clock) begin
      if (reset) start <= 1'b0;
      else begin
         if (start && !busy) expected_results.push_back(predict_word(live_word));
         if (!start || !busy) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle) begin
               next_word = pending_words.pop_front();
               start <= 1'b1;
               live_word <= next_word;
               req_action <= next_word.action;
               req_center_x <= next_word.cx;
               req_center_y <= next_word.cy;
               req_center_z <= next_word.cz;
               req_radius <= next_word.radius;
               req_voxel_index <= next_word.vidx;
            end else start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result word with nothing expected");
            fails++;
         end else begin
            got = expected_results.pop_front();
            if (rsp_distance !== got.distance) begin
               $error("distance expected %0d actual %0d", got.distance, rsp_distance);
               fails++;
            end
            if (rsp_status !== got.status) begin
               $error("status expected %0d actual %0d", got.status, rsp_status);
               fails++;
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_ORIGIN_X:   org_x = longint'($signed(v));
         CSR_ORIGIN_Y:   org_y = longint'($signed(v));
         CSR_ORIGIN_Z:   org_z = longint'($signed(v));
         CSR_CELL_SIZE:  cell_q = 64'(v[30:0]);
         CSR_INV_CELL:   inv_q = 64'(v[30:0]);
         CSR_RAD_SCALE:  rscale_q = 64'(v[23:0]);
         CSR_MAX_RADIUS: maxr_q = 64'(v[30:0]);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(logic [31:0] ox, oy, oz, cs, ics, rsc, mr);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_CELL_SIZE, cs);
      write_reg(CSR_INV_CELL, ics);
      write_reg(CSR_RAD_SCALE, rsc);
      write_reg(CSR_MAX_RADIUS, mr);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || start || expected_results.size() != 0 || busy);
   endtask

   function automatic logic [30:0] radius_limit();
      longint unsigned t;
      if (rscale_q == 0) return 31'h7FFF_FFFF;
      t = ((cell_q == 0 ? 64'd65536 : cell_q) << 16) / rscale_q;
      return t > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : t[30:0];
   endfunction

   function automatic logic [31:0] near_coord(longint o);
      longint c;
      c = o + (longint'($urandom_range(66)) - 2) * longint'(cell_q) +
          longint'($urandom_range(32'(cell_q > 0 ? cell_q - 1 : 0)));
      return c[31:0];
   endfunction

   task automatic queue_word(logic [1:0] a, logic [31:0] x, y, z, logic [30:0] r,
                             logic [17:0] v);
      pending_words.push_back('{a, x, y, z, r, v});
   endtask

   function automatic int vox(int x, int y, int z);
      return (z * GY + y) * GX + x;
   endfunction

   task automatic queue_random(int count);
      sphere_word_type w;
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         w.action = ACT_SPLAT;
         w.cx = near_coord(org_x);
         w.cy = near_coord(org_y);
         w.cz = near_coord(org_z);
         w.radius = 31'($urandom_range(radius_limit()));
         w.vidx = 18'($urandom);
         if (pick < 25) begin
            w.action = ACT_READ;
            if (touched.size() > 0 && pick < 13)
               w.vidx = 18'(touched[$urandom_range(touched.size() - 1)]);
         end else if (pick >= 88) begin
            // noise: any field value but a clear, expensive spheres kept small
            w.action = 2'($urandom_range(3));
            if (w.action == ACT_CLEAR) w.action = 2'd3;
            w.cx = $urandom;
            w.cy = $urandom;
            w.cz = $urandom;
            w.radius = 31'($urandom);
            if (splat_taken(w)) w.radius = 31'($urandom_range(radius_limit()));
         end
         pending_words.push_back(w);
      end
   endtask

   initial begin
      fails = 0;
      sender_idle = 13;
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_NONE;
      csr_wdata = '0;
      req_action = ACT_READ;
      req_center_x = '0;
      req_center_y = '0;
      req_center_z = '0;
      req_radius = '0;
      req_voxel_index = '0;
      foreach (sdf_grid[k]) sdf_grid[k] = FAR_VALUE;
      org_x = 0; org_y = 0; org_z = 0;
      cell_q = 65536; inv_q = 65536; rscale_q = 65536; maxr_q = 65536;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      queue_word(ACT_READ, 0, 0, 0, 0, 18'd0);
      queue_word(ACT_SPLAT, 0, 0, 0, 0, 0);
      queue_word(ACT_SPLAT, 63 << 16, 63 << 16, 63 << 16, 31'h0001_8000, 0);
      queue_word(ACT_SPLAT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      queue_word(ACT_SPLAT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 0);
      queue_word(ACT_SPLAT, -(2 << 16), 5 << 16, 5 << 16, 0, 0);      // on the grow edge
      queue_word(ACT_SPLAT, -(2 << 16) - 1, 5 << 16, 5 << 16, 0, 0);  // just past it
      queue_word(ACT_SPLAT, 65 << 16, 5 << 16, 5 << 16, 0, 0);        // empty box
      queue_word(ACT_SPLAT, 32'h000A_8000, 32'h0014_4000, 32'h001E_C000, 31'h0000_C000, 0);
      queue_word(ACT_READ, 0, 0, 0, 0, 18'h3FFFF);
      queue_word(ACT_READ, 0, 0, 0, 0, 18'(vox(63, 63, 63)));
      queue_word(ACT_READ, 0, 0, 0, 0, 18'(vox(10, 20, 30)));
      queue_word(ACT_READ, 0, 0, 0, 0, 18'(vox(11, 20, 31)));
      queue_word(2'd3, 32'h1234_5678, 0, 0, 31'h7FFF_FFFF, 18'h3FFFF);
      queue_word(ACT_READ, 0, 0, 0, 0, 18'(vox(1, 1, 1)));
      queue_word(ACT_CLEAR, 0, 0, 0, 0, 0);
      queue_word(ACT_READ, 0, 0, 0, 0, 18'(vox(10, 20, 30)));
      queue_random(170);
      wait_drained();

      set_regs(32'h8000_0000, 32'h7FFF_0000, 32'hFFFC_8000, 32'd32768, 32'd131072,
               32'h00FF_FFFF, 32'h7FFF_FFFF);
      queue_random(180);
      wait_drained();

      sender_idle = 59;
      set_regs(32'h7FFF_FFFF, 32'd0, 32'h1234_5678, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0);
      queue_word(ACT_CLEAR, 0, 0, 0, 0, 0);
      queue_random(180);
      wait_drained();

      set_regs($urandom, $urandom, $urandom, 32'd1, 32'h7FFF_FFFF, 32'd98304, 32'd1000);
      queue_random(180);
      wait_drained();

      sender_idle = 0;
      set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536);
      queue_word(ACT_CLEAR, 0, 0, 0, 0, 0);
      queue_random(180);
      wait_drained();

      set_regs(32'hFFF0_0000 + $urandom_range(32'hFFFFF), $urandom_range(32'hFFFFF),
               32'hFFF8_0000, 32'd65536, 32'd65536, 32'd65536, 32'd65536);
      queue_random(180);
      wait_drained();

      repeat (20) @(posedge clock);
      if (fails == 0)
         $display("[sphere_distance_field_splat] OK");
      else
         $display("[sphere_distance_field_splat] ERROR");
      $finish;
   end

endmodule
